### rtl/uenc_pkg.sv
// Shared types, constants and helper functions of the URI percent encoder.
package uenc_pkg;

	typedef enum logic [1:0] {
		K_CHAR = 2'd0,  // one unescaped character
		K_ERR  = 2'd1,  // one error word
		K_UTF8 = 2'd2   // one to four octets, percent encoded
	} kind_t;

	// Work descriptor passed from the front end to the back end.
	typedef struct packed {
		kind_t       kind;
		logic [20:0] value;  // code point, or the character for K_CHAR
		logic [1:0]  nbm1;   // octet count minus one
		logic        last;   // word belongs to the string's final unit
	} desc_t;

	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_LAST   = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE  = 21'h10000;
	localparam logic [6:0]  CHAR_PCT   = 7'h25;
	localparam logic [6:0]  CHAR_NUL   = 7'h00;

	function automatic logic is_unescaped(input logic [15:0] u, input logic comp);
		logic [6:0] c;
		logic       alnum;
		logic       mark;
		logic       resv;
		c     = u[6:0];
		alnum = (c >= 7'h30 && c <= 7'h39) || (c >= 7'h41 && c <= 7'h5A)
			|| (c >= 7'h61 && c <= 7'h7A);
		mark  = (c == 7'h2D) || (c == 7'h5F) || (c == 7'h2E) || (c == 7'h21)
			|| (c == 7'h7E) || (c == 7'h2A) || (c == 7'h27) || (c == 7'h28)
			|| (c == 7'h29);
		resv  = (c == 7'h3B) || (c == 7'h2F) || (c == 7'h3F) || (c == 7'h3A)
			|| (c == 7'h40) || (c == 7'h26) || (c == 7'h3D) || (c == 7'h2B)
			|| (c == 7'h24) || (c == 7'h2C) || (c == 7'h23);
		return (u[15:7] == 9'd0) && (alnum || mark || (resv && !comp));
	endfunction

	// Uppercase hex digit.
	function automatic logic [6:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (7'h30 + {3'd0, n}) : (7'h37 + {3'd0, n});
	endfunction

endpackage

### rtl/uenc_if.sv
// Channel interfaces of the URI percent encoder.
interface uenc_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        last_unit;
	modport source(output valid, code_unit, last_unit, input ready);
	modport sink(input valid, code_unit, last_unit, output ready);
endinterface

interface uenc_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       last_of_run;
	logic       string_end;
	logic       error;
	modport source(output valid, out_char, last_of_run, string_end, error, input ready);
	modport sink(input valid, out_char, last_of_run, string_end, error, output ready);
endinterface

interface uenc_cfg_if;
	logic valid;
	logic ready;
	logic component_mode;
	modport source(output valid, component_mode, input ready);
	modport sink(input valid, component_mode, output ready);
endinterface

### rtl/uenc_front.sv
// Front end: accepts code units, pairs surrogates, classifies into descriptors.
module uenc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           comp_mode,
	input  logic           full,
	output logic           push,
	output uenc_pkg::desc_t wdata,
	uenc_in_if.sink        units
);
	import uenc_pkg::*;

	logic       failed_q;
	logic       pend_q;
	logic [9:0] held_q;

	logic       acc;
	logic       is_low;
	logic       is_high;
	logic       err;
	logic       hold;
	logic       failed_d;
	logic [15:0] u;

	assign units.ready = !full;
	assign acc         = units.valid && units.ready;
	assign u           = units.code_unit;
	assign is_low      = (u >= LOW_FIRST) && (u <= LOW_LAST);
	assign is_high     = (u >= HIGH_FIRST) && (u <= HIGH_LAST);

	always_comb begin
		push       = 1'b0;
		err        = 1'b0;
		hold       = 1'b0;
		failed_d   = failed_q;
		wdata.kind  = K_CHAR;
		wdata.value = {5'd0, u};
		wdata.nbm1  = 2'd0;
		wdata.last  = units.last_unit;
		if (failed_q) begin
			if (units.last_unit)
				failed_d = 1'b0;
		end else if (pend_q) begin
			if (is_low) begin
				push        = 1'b1;
				wdata.kind  = K_UTF8;
				wdata.value = SUPP_BASE + {1'b0, held_q, u[9:0]};
				wdata.nbm1  = 2'd3;
			end else begin
				err = 1'b1;
			end
		end else if (is_unescaped(u, comp_mode)) begin
			push       = 1'b1;
			wdata.kind = K_CHAR;
		end else if (is_low) begin
			err = 1'b1;
		end else if (is_high) begin
			if (units.last_unit)
				err = 1'b1;
			else
				hold = 1'b1;
		end else begin
			push       = 1'b1;
			wdata.kind = K_UTF8;
			if (u < 16'h0080)
				wdata.nbm1 = 2'd0;
			else if (u < 16'h0800)
				wdata.nbm1 = 2'd1;
			else
				wdata.nbm1 = 2'd2;
		end
		if (err) begin
			push       = 1'b1;
			wdata.kind = K_ERR;
			failed_d   = !units.last_unit;
		end
		push = push && acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q <= 1'b0;
			pend_q   <= 1'b0;
		end else if (acc) begin
			failed_q <= failed_d;
			pend_q   <= hold;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && hold)
			held_q <= u[9:0] - HIGH_FIRST[9:0];
	end

endmodule

### rtl/uenc_fifo.sv
// Short descriptor queue between front and back end, head read in place.
module uenc_fifo #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  uenc_pkg::desc_t wdata,
	input  logic            pop,
	output uenc_pkg::desc_t head,
	output logic            full,
	output logic            empty
);
	import uenc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);

	desc_t          mem_q [DEPTH];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [CW-1:0]  cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == PTR_MAX) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == PTR_MAX) ? '0 : rptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### rtl/uenc_back.sv
// Back end: expands the head descriptor into characters, one per cycle while the output is not stalled.
module uenc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  uenc_pkg::desc_t head,
	input  logic            head_valid,
	output logic            pop,
	uenc_out_if.source      chars
);
	import uenc_pkg::*;

	localparam logic [1:0] DIG_PCT = 2'd0;
	localparam logic [1:0] DIG_HI  = 2'd1;
	localparam logic [1:0] DIG_LO  = 2'd2;

	logic [1:0] dig_q;
	logic [1:0] oct_q;
	logic       out_valid_q;
	logic [6:0] char_q;
	logic       lor_q;
	logic       send_q;
	logic       err_q;

	logic       advance;
	logic       final_char;
	logic [1:0] rem;
	logic [7:0] octet;
	logic [6:0] ch;

	assign advance    = !out_valid_q || chars.ready;
	assign final_char = (head.kind != K_UTF8) || ((oct_q == head.nbm1) && (dig_q == DIG_LO));
	assign pop        = advance && head_valid && final_char;
	assign rem        = head.nbm1 - oct_q;

	always_comb begin
		if (oct_q == 2'd0) begin
			unique case (head.nbm1)
				2'd0: octet = {1'b0, head.value[6:0]};
				2'd1: octet = {3'b110, head.value[10:6]};
				2'd2: octet = {4'b1110, head.value[15:12]};
				2'd3: octet = {5'b11110, head.value[20:18]};
			endcase
		end else begin
			unique case (rem)
				2'd0:    octet = {2'b10, head.value[5:0]};
				2'd1:    octet = {2'b10, head.value[11:6]};
				default: octet = {2'b10, head.value[17:12]};
			endcase
		end
	end

	always_comb begin
		unique case (head.kind)
			K_CHAR:  ch = head.value[6:0];
			K_ERR:   ch = CHAR_NUL;
			K_UTF8: begin
				unique case (dig_q)
					DIG_HI:  ch = hex_char(octet[7:4]);
					DIG_LO:  ch = hex_char(octet[3:0]);
					default: ch = CHAR_PCT;
				endcase
			end
			default: ch = CHAR_NUL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			dig_q       <= DIG_PCT;
			oct_q       <= 2'd0;
		end else if (advance) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				if (final_char) begin
					dig_q <= DIG_PCT;
					oct_q <= 2'd0;
				end else if (dig_q == DIG_LO) begin
					dig_q <= DIG_PCT;
					oct_q <= oct_q + 2'd1;
				end else begin
					dig_q <= dig_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && head_valid) begin
			char_q <= ch;
			lor_q  <= final_char;
			send_q <= final_char && head.last;
			err_q  <= (head.kind == K_ERR);
		end
	end

	assign chars.valid       = out_valid_q;
	assign chars.out_char    = char_q;
	assign chars.last_of_run = lor_q;
	assign chars.string_end  = send_q;
	assign chars.error       = err_q;

endmodule

### rtl/uri_percent_encoder.sv
// Top level of the URI percent encoder (encodeURI / encodeURIComponent, UTF-8).
//
//  channel  role  word
//  -------  ----  -----------------------------------------------------------
//  cfg      sink  component_mode: 0 full URI set, 1 component set (always ready)
//  units    sink  code_unit[15:0], last_unit: one UTF-16 code unit
//  chars    src   out_char[6:0], last_of_run, string_end, error
//
//  Output: a unit is classified in the cycle it is accepted; the back end then
//  sends one character per cycle while chars is not stalled; a unit yields one
//  character (unescaped or error) or three per octet (one to three octets), and
//  a surrogate pair four octets on its low unit. A held high surrogate or a
//  dropped unit produces no output character.
//  Reset: arst_n clears surrogate/failure state, the queue and the output valid flag.
//  Stalls: the queue of FIFO_DEPTH descriptors lets the front keep accepting
//  while chars is stalled; units.ready drops only when the queue is full.
module uri_percent_encoder #(
	parameter int FIFO_DEPTH = 2
) (
	input  logic     clk,
	input  logic     arst_n,
	uenc_cfg_if.sink cfg,
	uenc_in_if.sink  units,
	uenc_out_if.source chars
);
	import uenc_pkg::*;

	logic  comp_mode_q;
	logic  push;
	logic  pop;
	logic  full;
	logic  empty;
	desc_t wdata;
	desc_t head;

	// configuration register; the user must write it only while idle (the block does not enforce this)
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			comp_mode_q <= 1'b0;
		else if (cfg.valid)
			comp_mode_q <= cfg.component_mode;
	end

	// front: accept, pair surrogates, track failed strings
	uenc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.comp_mode (comp_mode_q),
		.full      (full),
		.push      (push),
		.wdata     (wdata),
		.units     (units)
	);

	// descriptor queue decoupling classification from character output
	uenc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	// back: percent expansion with registered output word
	uenc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!empty),
		.pop        (pop),
		.chars      (chars)
	);

endmodule

### rtl/uenc_checker.sv
// Port-level assertions for the URI percent encoder, bound to the top level.
module uenc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] out_char,
	input logic       last_of_run,
	input logic       string_end,
	input logic       error
);

	// error word carries NUL and closes its run
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> (out_char == 7'd0) && last_of_run)
		else $error("error word malformed");

	// string end only on the final word of a run
	a_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_end |-> last_of_run)
		else $error("string_end without last_of_run");

	// normal words are never NUL
	a_no_nul: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !error |-> (out_char != 7'd0))
		else $error("NUL character on a normal word");

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char)
			&& $stable(last_of_run) && $stable(string_end) && $stable(error))
		else $error("stalled word changed");

endmodule

bind uri_percent_encoder uenc_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (chars.valid),
	.out_ready   (chars.ready),
	.out_char    (chars.out_char),
	.last_of_run (chars.last_of_run),
	.string_end  (chars.string_end),
	.error       (chars.error)
);

### dv/tb_uri_percent_encoder.sv
// Self-checking testbench of the URI percent encoder: directed and random UTF-16 strings.
`timescale 1ns / 100ps

module tb_uri_percent_encoder;
	import uenc_pkg::*;

	// Watchdog: cycles in a row with no handshake on any channel.
	localparam int unsigned HANG_LIMIT = 4000;
	// Cycles allowed for the front end to settle once no word is outstanding.
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned REPORT_MAX = 10;

	// One expected or observed output word.
	typedef struct packed {
		logic [6:0] ch;
		logic       run_end;
		logic       str_end;
		logic       err;
	} char_word_t;

	// Predicts the encoder's words per accepted code unit and checks them in order.
	class char_scoreboard;
		bit         comp_mode;
		bit [9:0]   held_bits;
		bit         high_held;
		bit         dropping;
		char_word_t run_chars[$];
		char_word_t expected_chars[$];
		int unsigned n_units, n_checked, n_mismatch, n_err_words, n_pairs;

		function bit is_plain(bit [15:0] u);
			bit [7:0] c;
			c = u[7:0];
			if (u[15:8] != 8'd0)
				return 1'b0;
			if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
				return 1'b1;
			case (c)
				"-", "_", ".", "!", "~", "*", "'", "(", ")": return 1'b1;
				";", "/", "?", ":", "@", "&", "=", "+", "$", ",", "#": return !comp_mode;
				default: return 1'b0;
			endcase
		endfunction

		function void add_char(bit [6:0] c, bit e);
			char_word_t w;
			w.ch      = c;
			w.run_end = 1'b0;
			w.str_end = 1'b0;
			w.err     = e;
			run_chars.push_back(w);
		endfunction

		function bit [6:0] hex_digit(bit [3:0] n);
			return (n < 4'd10) ? 7'("0") + 7'(n) : 7'("A") + 7'(n) - 7'd10;
		endfunction

		function void add_octet(bit [7:0] o);
			add_char(CHAR_PCT, 1'b0);
			add_char(hex_digit(o[7:4]), 1'b0);
			add_char(hex_digit(o[3:0]), 1'b0);
		endfunction

		function void add_utf8(bit [20:0] v);
			if (v < 21'h80) begin
				add_octet(v[7:0]);
			end else if (v < 21'h800) begin
				add_octet({3'b110, v[10:6]});
				add_octet({2'b10, v[5:0]});
			end else if (v < 21'h10000) begin
				add_octet({4'b1110, v[15:12]});
				add_octet({2'b10, v[11:6]});
				add_octet({2'b10, v[5:0]});
			end else begin
				add_octet({5'b11110, v[20:18]});
				add_octet({2'b10, v[17:12]});
				add_octet({2'b10, v[11:6]});
				add_octet({2'b10, v[5:0]});
			end
		endfunction

		function void note_unit(bit [15:0] u, bit last);
			bit        low_u, high_u, fail;
			bit [20:0] cp;
			low_u  = (u >= LOW_FIRST) && (u <= LOW_LAST);
			high_u = (u >= HIGH_FIRST) && (u <= HIGH_LAST);
			fail   = 1'b0;
			n_units++;
			run_chars.delete();
			if (dropping) begin
				if (last)
					dropping = 1'b0;
				return;
			end
			if (high_held) begin
				high_held = 1'b0;
				if (low_u) begin
					cp = {1'b0, held_bits, 10'd0} + 21'(u - LOW_FIRST) + SUPP_BASE;
					add_utf8(cp);
					n_pairs++;
				end else begin
					fail = 1'b1;
				end
				held_bits = '0;
			end else if (is_plain(u)) begin
				add_char(u[6:0], 1'b0);
			end else if (low_u) begin
				fail = 1'b1;
			end else if (high_u) begin
				if (last) begin
					fail = 1'b1;
				end else begin
					// park the high half, nothing comes out yet
					held_bits = u[9:0];
					high_held = 1'b1;
					return;
				end
			end else begin
				add_utf8({5'd0, u});
			end
			if (fail) begin
				add_char(CHAR_NUL, 1'b1);
				dropping = !last;
				n_err_words++;
			end
			run_chars[run_chars.size() - 1].run_end = 1'b1;
			run_chars[run_chars.size() - 1].str_end = last;
			foreach (run_chars[i])
				expected_chars.push_back(run_chars[i]);
		endfunction

		function void check_char(char_word_t got);
			char_word_t want;
			n_checked++;
			if (expected_chars.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= REPORT_MAX)
					$display("ERROR: unexpected word ch=%h run_end=%b str_end=%b err=%b",
						got.ch, got.run_end, got.str_end, got.err);
				return;
			end
			want = expected_chars.pop_front();
			if (got !== want) begin
				n_mismatch++;
				if (n_mismatch <= REPORT_MAX)
					$display({"ERROR: word %0d exp ch=%h run_end=%b str_end=%b err=%b,",
						" got ch=%h run_end=%b str_end=%b err=%b"},
						n_checked, want.ch, want.run_end, want.str_end, want.err,
						got.ch, got.run_end, got.str_end, got.err);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	uenc_cfg_if cfg_bus();
	uenc_in_if  unit_bus();
	uenc_out_if char_bus();

	uri_percent_encoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.units  (unit_bus),
		.chars  (char_bus)
	);

	char_scoreboard sb;
	int unsigned    send_gap_pct;  // chance per cycle that the sender holds off
	int unsigned    stall_pct;     // chance per cycle that the receiver stalls
	int unsigned    hang_count;
	int unsigned    units_sent;
	bit [1:0]       modes_seen;

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Everything starts known; the only reset of the run.
	initial begin
		sb                      = new;
		arst_n                  = 1'b0;
		cfg_bus.valid           = 1'b0;
		cfg_bus.component_mode  = 1'b0;
		unit_bus.valid          = 1'b0;
		unit_bus.code_unit      = '0;
		unit_bus.last_unit      = 1'b0;
		char_bus.ready          = 1'b0;
		send_gap_pct            = 0;
		stall_pct               = 0;
		hang_count              = 0;
		units_sent              = 0;
		modes_seen              = 2'b01;
	end

	// Receiver: random backpressure at the current stall rate.
	always @(posedge clk) begin
		char_bus.ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	// Monitor: every handshake is sampled at the edge that completes it.
	// A unit accepted this edge cannot produce a word in the same edge, so
	// noting it before checking leaves the head of the queue untouched.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready)
				sb.comp_mode = cfg_bus.component_mode;
			if (unit_bus.valid && unit_bus.ready)
				sb.note_unit(unit_bus.code_unit, unit_bus.last_unit);
			if (char_bus.valid && char_bus.ready)
				sb.check_char({char_bus.out_char, char_bus.last_of_run,
					char_bus.string_end, char_bus.error});
		end
	end

	// Watchdog: a long stretch with no word moving on any channel is a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cfg_bus.valid && cfg_bus.ready) || (unit_bus.valid && unit_bus.ready)
				|| (char_bus.valid && char_bus.ready)) begin
				hang_count <= 0;
			end else if (hang_count >= HANG_LIMIT) begin
				$display("TIMEOUT: no handshake for %0d cycles", HANG_LIMIT);
				$display("Test completed with failures");
				$finish;
			end else begin
				hang_count <= hang_count + 1;
			end
		end
	end

	// Blocks until every predicted word has come back. The first edge lets
	// the monitor note a unit accepted at the edge the caller returned on.
	task automatic wait_drained();
		@(posedge clk);
		while (sb.expected_chars.size() != 0)
			@(posedge clk);
	endtask

	// Mode writes only with the encoder idle. A held high surrogate or a
	// dropped unit leaves no word behind, so give the front end time to settle.
	task automatic write_mode(input bit m);
		unit_bus.valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_bus.valid          <= 1'b1;
		cfg_bus.component_mode <= m;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		cfg_bus.valid <= 1'b0;
		modes_seen[m] = 1'b1;
	endtask

	// Offers one code unit and returns at the edge where it is accepted.
	// valid stays high into the next word unless the sender decides to idle.
	task automatic send_unit(input bit [15:0] u, input bit last);
		while ($urandom_range(99) < send_gap_pct) begin
			unit_bus.valid <= 1'b0;
			@(posedge clk);
		end
		unit_bus.valid     <= 1'b1;
		unit_bus.code_unit <= u;
		unit_bus.last_unit <= last;
		@(posedge clk);
		while (!unit_bus.ready)
			@(posedge clk);
		units_sent++;
	endtask

	// One random string. Mostly well-formed text with surrogate pairs; a
	// minority of lone surrogates and raw 16-bit noise to hit the error path.
	task automatic send_random_string();
		int unsigned len, i, sel;
		bit [15:0]   u;
		len = $urandom_range(1, 10);
		i   = 0;
		while (i < len) begin
			sel = $urandom_range(99);
			if (sel < 30) begin
				u = 16'($urandom_range(32, 126));
			end else if (sel < 40) begin
				u = 16'($urandom_range(0, 127));
			end else if (sel < 55) begin
				u = 16'($urandom_range(16'h80, 16'h7FF));
			end else if (sel < 70) begin
				u = 16'($urandom_range(16'h800, 16'hFFFF));
			end else if (sel < 88) begin
				// valid pair; the low half may close the string
				send_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), 1'b0);
				i++;
				u = 16'($urandom_range(LOW_FIRST, LOW_LAST));
			end else if (sel < 92) begin
				u = 16'($urandom_range(LOW_FIRST, LOW_LAST));
			end else if (sel < 95) begin
				u = 16'($urandom_range(HIGH_FIRST, HIGH_LAST));
			end else begin
				u = 16'($urandom());
			end
			i++;
			send_unit(u, i >= len);
		end
	endtask

	// One traffic mix: mode, sender gap rate, receiver stall rate, unit count.
	// With hold_mid set, the sender stops halfway until all words are back.
	task automatic run_phase(input bit m, input int unsigned gap, input int unsigned stall,
		input int unsigned n_units, input bit hold_mid);
		int unsigned start;
		bit          held;
		write_mode(m);
		send_gap_pct = gap;
		stall_pct    = stall;
		start        = units_sent;
		held         = 1'b0;
		while (units_sent - start < n_units) begin
			send_random_string();
			if (hold_mid && !held && (units_sent - start >= n_units / 2)) begin
				unit_bus.valid <= 1'b0;
				wait_drained();
				held = 1'b1;
			end
		end
		unit_bus.valid <= 1'b0;
	endtask

	initial begin
		#0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, full URI set (reset mode): a letter, a digit, a mark, a
		// reserved character that passes, then every UTF-8 length boundary.
		send_unit("A", 1'b0);
		send_unit("0", 1'b0);
		send_unit("-", 1'b0);
		send_unit(";", 1'b0);
		send_unit(16'h0020, 1'b0);
		send_unit(16'h0000, 1'b0);
		send_unit(16'h007F, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h07FF, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hFFFF, 1'b0);
		// lowest and highest surrogate pairs, the second closes the string
		send_unit(HIGH_FIRST, 1'b0);
		send_unit(LOW_FIRST, 1'b0);
		send_unit(HIGH_LAST, 1'b0);
		send_unit(LOW_LAST, 1'b1);
		// lone low surrogate mid-string: error, rest of string dropped
		send_unit(LOW_FIRST, 1'b0);
		send_unit("B", 1'b0);
		send_unit("C", 1'b1);
		// high surrogate followed by a non-low unit: error, then drop
		send_unit(HIGH_FIRST, 1'b0);
		send_unit("x", 1'b0);
		send_unit("y", 1'b1);
		// high surrogate as the final unit, then lone low as the final unit
		send_unit(HIGH_LAST, 1'b1);
		send_unit(LOW_LAST, 1'b1);

		// Directed, component set: reserved characters now get escaped.
		write_mode(1'b1);
		send_unit(";", 1'b0);
		send_unit("#", 1'b0);
		send_unit("~", 1'b1);

		run_phase(1'b0, 0, 0, 110, 1'b0);
		run_phase(1'b1, 64, 0, 110, 1'b1);
		run_phase(1'b0, 0, 64, 110, 1'b0);
		run_phase(1'b1, 9, 9, 110, 1'b0);

		wait_drained();
		repeat (24) @(posedge clk);

		$display("Covered %0d code units (%0d surrogate pairs), %0d words checked, %0d error words",
			sb.n_units, sb.n_pairs, sb.n_checked, sb.n_err_words);
		$display("Modes used: %s, traffic mixes with and without sender gaps and receiver stalls",
			(modes_seen == 2'b11) ? "full URI and component" : "one only");
		if (sb.expected_chars.size() != 0)
			$display("ERROR: %0d expected words never arrived", sb.expected_chars.size());
		if (sb.n_mismatch > 0)
			$display("ERROR: %0d mismatched words", sb.n_mismatch);
		if (sb.n_mismatch == 0 && sb.expected_chars.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/uenc_pkg.sv
rtl/uenc_if.sv
rtl/uenc_front.sv
rtl/uenc_fifo.sv
rtl/uenc_back.sv
rtl/uri_percent_encoder.sv
rtl/uenc_checker.sv
dv/tb_uri_percent_encoder.sv
